>>> hw/rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared constants, codes and types of the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RELEASE = 16;

	localparam int TASK_W  = 8;
	localparam int DELAY_W = 32;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int REL_W   = $clog2(MAX_RELEASE + 1);

	// input item kinds
	localparam logic KIND_ALARM = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// result kinds
	localparam logic EVENT_STATUS  = 1'b0;
	localparam logic EVENT_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_ACCEPTED = 2'd0,
		STATUS_IGNORED  = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP,
		ST_DEC,
		ST_REL
	} state_t;

	// alarm request travelling down the chain
	typedef struct packed {
		logic               v;
		logic [DELAY_W-1:0] rem;
		logic [TASK_W-1:0]  task_id;
	} tok_t;

	// commands to a cell; shift_left reaches every cell, dec only the first
	typedef struct packed {
		logic shift_left;
		logic dec;
	} cell_ctl_t;

	// what the controller sees of the front of the list
	typedef struct packed {
		logic [DELAY_W-1:0] delta;
		logic [TASK_W-1:0]  task_id;
		logic [DELAY_W-1:0] nxt_delta;
	} head_t;

endpackage

>>> hw/rtl/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell
// One list entry: delta and task id, plus a slot for a passing alarm request.
// ----------------------------------------------------------------------------
module dltq_cell import dltq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic               valid,
	input  tok_t               tok_in,
	input  logic               shift_in,
	input  logic [DELAY_W-1:0] carry_in_delta,
	input  logic [TASK_W-1:0]  carry_in_task,
	input  logic [DELAY_W-1:0] nxt_delta,
	input  logic [TASK_W-1:0]  nxt_task,
	output tok_t               tok_out,
	output logic               shift_out,
	output logic [DELAY_W-1:0] carry_delta,
	output logic [TASK_W-1:0]  carry_task,
	output logic [DELAY_W-1:0] delta,
	output logic [TASK_W-1:0]  task_id,
	output logic               tok_busy
);

	logic               tok_v_q;
	logic [DELAY_W-1:0] tok_rem_q;
	logic [TASK_W-1:0]  tok_task_q;
	logic [DELAY_W-1:0] delta_q;
	logic [TASK_W-1:0]  task_q;
	logic               pass;
	logic               ins;

	// request moves on while its delay is at least this entry's delta
	assign pass = tok_v_q && valid && (tok_rem_q >= delta_q);
	assign ins  = tok_v_q && !pass;

	assign tok_out.v       = pass;
	assign tok_out.rem     = tok_rem_q - delta_q;
	assign tok_out.task_id = tok_task_q;

	assign shift_out   = ins || shift_in;
	assign carry_delta = ins ? (delta_q - tok_rem_q) : delta_q;
	assign carry_task  = task_q;

	assign delta    = delta_q;
	assign task_id  = task_q;
	assign tok_busy = tok_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_in.v;
		end
	end

	always_ff @(posedge clk) begin
		tok_rem_q  <= tok_in.rem;
		tok_task_q <= tok_in.task_id;
		priority if (ins) begin
			delta_q <= tok_rem_q;
			task_q  <= tok_task_q;
		end else if (shift_in) begin
			delta_q <= carry_in_delta;
			task_q  <= carry_in_task;
		end else if (ctl.shift_left) begin
			delta_q <= nxt_delta;
			task_q  <= nxt_task;
		end else if (ctl.dec) begin
			delta_q <= delta_q - DELAY_W'(1);
		end
	end

endmodule

>>> hw/rtl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer: takes items, drives the cell chain, keeps the entry count and
// the output register.
// ----------------------------------------------------------------------------
module dltq_ctrl import dltq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_kind,
	input  logic [TASK_W-1:0]  in_task,
	input  logic [DELAY_W-1:0] in_delay,
	input  head_t              head,
	input  logic               ins_done,
	output tok_t               tok_inj,
	output cell_ctl_t          ctl,
	output logic [COUNT_W-1:0] count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_event,
	output logic [TASK_W-1:0]  out_task,
	output status_t            out_status,
	output logic               out_last
);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q;
	logic [REL_W-1:0]   rel_cnt_q;
	status_t            status_q;
	logic               out_valid_q;
	logic               out_event_q;
	logic [TASK_W-1:0]  out_task_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic accept;
	logic full;
	logic out_free;
	logic can_rel;
	logic rel_last;
	logic load_rel;
	logic load_resp;

	assign accept   = in_valid && in_ready;
	assign full     = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign can_rel  = (count_q != '0) && (head.delta == '0)
		&& (rel_cnt_q != REL_W'(MAX_RELEASE));
	assign rel_last = (count_q == COUNT_W'(1)) || (head.nxt_delta != '0)
		|| (rel_cnt_q == REL_W'(MAX_RELEASE - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_kind == KIND_TICK) begin
						state_d = (count_q == '0) ? ST_IDLE : ST_DEC;
					end else if (in_delay == '0 || full) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (ins_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_DEC: begin
				state_d = ST_REL;
			end
			ST_REL: begin
				if (!can_rel) begin
					state_d = ST_IDLE;
				end else if (out_free && rel_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == ST_IDLE);
		tok_inj.v       = accept && (in_kind == KIND_ALARM) && (in_delay != '0) && !full;
		tok_inj.rem     = in_delay;
		tok_inj.task_id = in_task;
		ctl.dec         = (state_q == ST_DEC) && (head.delta != '0);
		load_rel        = (state_q == ST_REL) && can_rel && out_free;
		ctl.shift_left  = load_rel;
		load_resp       = (state_q == ST_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rel_cnt_q   <= '0;
			status_q    <= STATUS_ACCEPTED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_done) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (load_rel) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (accept) begin
				rel_cnt_q <= '0;
			end else if (load_rel) begin
				rel_cnt_q <= rel_cnt_q + REL_W'(1);
			end
			if (accept && in_kind == KIND_ALARM) begin
				status_q <= (in_delay == '0) ? STATUS_IGNORED : STATUS_FULL;
			end else if (ins_done) begin
				status_q <= STATUS_ACCEPTED;
			end
			if (load_rel || load_resp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rel) begin
			out_event_q  <= EVENT_RELEASE;
			out_task_q   <= head.task_id;
			out_status_q <= STATUS_ACCEPTED;
			out_last_q   <= rel_last;
		end else if (load_resp) begin
			out_event_q  <= EVENT_STATUS;
			out_task_q   <= '0;
			out_status_q <= status_q;
			out_last_q   <= 1'b1;
		end
	end

	assign count      = count_q;
	assign out_valid  = out_valid_q;
	assign out_event  = out_event_q;
	assign out_task   = out_task_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

>>> hw/rtl/delta_list_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_unit
// Timer queue held as a delta list in a row of entry cells.
// ----------------------------------------------------------------------------
// Input stream: tuser = kind (0 alarm request, 1 tick), tdata = task id and
// delay. Output stream: tuser = 0 for a request status, 1 for a released
// task; tdata = task id and status; tlast marks the last result of an item.
// An alarm request is passed into the first cell and moves one cell per
// cycle until its delay falls below the entry there or it meets an unused
// cell; it then takes that cell while the rest of the row moves one place
// down in the same cycle. A zero delay or a full queue only gives a status.
// A tick on an empty queue gives no result; otherwise it decrements a nonzero
// head delta, then releases up to MAX_RELEASE tasks whose delta is zero, the
// row moving up one place per release, and gives no result if none is due.
// One item is worked on at a time; the next is taken once the last result of
// the previous one is in the output register, or once a tick without result
// is done. Reset empties the queue at once and clears the output valid flag.
// While the receiver stalls the output register holds its result and the
// release sequence waits.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_unit import dltq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // task_id[7:0], delay_ticks[39:8]
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // released_task[7:0], status[9:8], zero[15:10]
	output logic        m_axis_tuser,   // event_res
	output logic        m_axis_tlast    // last
);

	tok_t               tok_l    [QUEUE_DEPTH+1];
	logic               sh       [QUEUE_DEPTH+1];
	logic [DELAY_W-1:0] carry_d  [QUEUE_DEPTH+1];
	logic [TASK_W-1:0]  carry_t  [QUEUE_DEPTH+1];
	logic [DELAY_W-1:0] delta_c  [QUEUE_DEPTH];
	logic [TASK_W-1:0]  task_c   [QUEUE_DEPTH];
	logic [DELAY_W-1:0] nxt_d    [QUEUE_DEPTH];
	logic [TASK_W-1:0]  nxt_t    [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] tok_busy;

	tok_t               tok_inj;
	cell_ctl_t          ctl;
	logic [COUNT_W-1:0] count;
	head_t              head;
	status_t            out_status;
	logic               ins_done;

	assign tok_l[0]   = tok_inj;
	assign sh[0]      = 1'b0;
	assign carry_d[0] = '0;
	assign carry_t[0] = '0;
	// insertion anywhere ends in a shift flag leaving the last cell
	assign ins_done   = sh[QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t cctl;
		logic      valid;

		assign cctl.shift_left = ctl.shift_left;
		assign cctl.dec        = (i == 0) ? ctl.dec : 1'b0;
		assign valid           = (COUNT_W'(i) < count);

		if (i < QUEUE_DEPTH - 1) begin : g_nxt
			assign nxt_d[i] = delta_c[i+1];
			assign nxt_t[i] = task_c[i+1];
		end else begin : g_end
			assign nxt_d[i] = '0;
			assign nxt_t[i] = '0;
		end

		dltq_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (cctl),
			.valid          (valid),
			.tok_in         (tok_l[i]),
			.shift_in       (sh[i]),
			.carry_in_delta (carry_d[i]),
			.carry_in_task  (carry_t[i]),
			.nxt_delta      (nxt_d[i]),
			.nxt_task       (nxt_t[i]),
			.tok_out        (tok_l[i+1]),
			.shift_out      (sh[i+1]),
			.carry_delta    (carry_d[i+1]),
			.carry_task     (carry_t[i+1]),
			.delta          (delta_c[i]),
			.task_id        (task_c[i]),
			.tok_busy       (tok_busy[i])
		);
	end

	assign head.delta     = delta_c[0];
	assign head.task_id   = task_c[0];
	assign head.nxt_delta = nxt_d[0];

	dltq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_task    (s_axis_tdata[7:0]),
		.in_delay   (s_axis_tdata[39:8]),
		.head       (head),
		.ins_done   (ins_done),
		.tok_inj    (tok_inj),
		.ctl        (ctl),
		.count      (count),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_event  (m_axis_tuser),
		.out_task   (m_axis_tdata[7:0]),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata[9:8]   = out_status;
	assign m_axis_tdata[15:10] = '0;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= COUNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_idle_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (tok_busy == '0))
		else $error("request still in chain while taking input");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_busy))
		else $error("more than one request in chain");

	a_insert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ins_done |-> !s_axis_tready && !ctl.shift_left)
		else $error("insertion while idle or releasing");

endmodule

>>> bench/delta_list_timer_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_unit_test
// Self-checking bench for the delta-list timer queue. A shadow copy of the
// list predicts every status and release; results are checked in order
// under random idling on both streams, a long output stall and full queues.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_unit_test;
	import dltq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int END_PAUSE      = 50;
	localparam int STALL_CYCLES   = 300;

	typedef struct packed {
		logic              is_release;
		logic [TASK_W-1:0] task_id;
		status_t           status;
		logic              last;
	} timer_event_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // task_id[7:0], delay_ticks[39:8]
	logic        s_axis_tuser;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // released_task[7:0], status[9:8], zero[15:10]
	logic        m_axis_tuser;   // event_res
	logic        m_axis_tlast;   // last

	// shadow of the delta list
	logic [DELAY_W-1:0] shadow_delta [QUEUE_DEPTH];
	logic [TASK_W-1:0]  shadow_task  [QUEUE_DEPTH];
	int                 shadow_count;

	timer_event_t awaited_events [$];

	int error_count;
	int requests_sent;
	int ticks_sent;
	int releases_due;
	int full_due;
	int ignored_due;
	int results_checked;

	int tx_max_gap;
	int rx_max_gap;
	int rx_hold_req;
	logic rx_holding;

	delta_list_timer_queue_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint exp_val,
			input longint got_val);
		error_count++;
		if (error_count <= 60)
			$display("%0t mismatch on result %0d: %s expected %0h got %0h",
				$realtime, results_checked, what, exp_val, got_val);
	endtask

	// apply one accepted item to the shadow list and queue its results
	task automatic advance_timer_queue(input logic kind, input logic [TASK_W-1:0] tid,
			input logic [DELAY_W-1:0] delay);
		timer_event_t       res;
		logic [DELAY_W-1:0] rest;
		int                 pos;
		int                 n;
		int                 i;
		res = '{is_release: EVENT_STATUS, task_id: '0, status: STATUS_ACCEPTED, last: 1'b1};
		if (kind == KIND_ALARM) begin
			requests_sent++;
			if (delay == '0) begin
				res.status = STATUS_IGNORED;
				ignored_due++;
			end else if (shadow_count >= QUEUE_DEPTH) begin
				res.status = STATUS_FULL;
				full_due++;
			end else begin
				rest = delay;
				pos = 0;
				while (pos < shadow_count && rest >= shadow_delta[pos]) begin
					rest -= shadow_delta[pos];
					pos++;
				end
				for (i = shadow_count; i > pos; i--) begin
					shadow_delta[i] = shadow_delta[i-1];
					shadow_task[i]  = shadow_task[i-1];
				end
				shadow_delta[pos] = rest;
				shadow_task[pos]  = tid;
				// follower keeps its total time
				if (pos < shadow_count && pos + 1 < QUEUE_DEPTH)
					shadow_delta[pos+1] -= rest;
				shadow_count++;
			end
			awaited_events.push_back(res);
		end else begin
			ticks_sent++;
			if (shadow_count > 0) begin
				// a head left at zero by a capped release goes out without a decrement
				if (shadow_delta[0] > 0)
					shadow_delta[0]--;
				n = 0;
				while (shadow_count > 0 && shadow_delta[0] == '0 && n < MAX_RELEASE) begin
					res.is_release = EVENT_RELEASE;
					res.task_id    = shadow_task[0];
					res.status     = STATUS_ACCEPTED;
					for (i = 1; i < shadow_count; i++) begin
						shadow_delta[i-1] = shadow_delta[i];
						shadow_task[i-1]  = shadow_task[i];
					end
					shadow_count--;
					n++;
					res.last = !(shadow_count > 0 && shadow_delta[0] == '0 && n < MAX_RELEASE);
					awaited_events.push_back(res);
					releases_due++;
				end
			end
		end
	endtask

	// one input transfer; entered and left at a falling edge
	task automatic offer_item(input logic kind, input logic [TASK_W-1:0] tid,
			input logic [DELAY_W-1:0] delay);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {delay, tid};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		advance_timer_queue(kind, tid, delay);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_events.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_request_edges();
		tx_max_gap = 12;
		rx_max_gap = 12;
		offer_item(KIND_ALARM, 8'h33, 32'd0);
		offer_item(KIND_TICK, 8'hC3, 32'hFFFF_FFFF);
		// never expires within the run: stays at the tail
		offer_item(KIND_ALARM, 8'hFF, 32'hFFFF_FFFF);
		offer_item(KIND_ALARM, 8'h00, 32'd1);
		// same total delay queues behind with a zero delta
		offer_item(KIND_ALARM, 8'h81, 32'd1);
		offer_item(KIND_ALARM, 8'h5A, 32'd3);
		offer_item(KIND_TICK, 8'h00, 32'd0);
		offer_item(KIND_TICK, 8'hFF, 32'h8000_0000);
		offer_item(KIND_TICK, 8'h12, 32'h0000_0001);
		wait_for_drain();
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < QUEUE_DEPTH - 1; i++)
			offer_item(KIND_ALARM, 8'(i * 17), 32'((i % 3) + 1));
		offer_item(KIND_ALARM, 8'hA5, 32'hFFFF_FFFF);
		// zero delay wins over full
		offer_item(KIND_ALARM, 8'h5A, 32'd0);
		wait_for_drain();
	endtask

	task automatic test_output_stall();
		int i;
		tx_max_gap = 0;
		rx_hold_req = STALL_CYCLES;
		while (!rx_holding)
			@(negedge clk);
		for (i = 0; i < 4; i++)
			offer_item(KIND_ALARM, 8'(8'hE0 + i), 32'd2);
		offer_item(KIND_TICK, 8'h00, 32'd0);
		offer_item(KIND_TICK, 8'h00, 32'd0);
		offer_item(KIND_ALARM, 8'h11, 32'd0);
		wait_for_drain();
		tx_max_gap = 12;
	endtask

	task automatic test_random_traffic(input int count, input int alarm_pct,
			input int tx_gap, input int rx_gap);
		int                 n;
		int                 pick;
		int                 sel;
		logic [DELAY_W-1:0] delay;
		tx_max_gap = tx_gap;
		rx_max_gap = rx_gap;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 59) == 0)
				wait_for_drain();
			if (pick >= alarm_pct) begin
				offer_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom());
			end else begin
				if (shadow_count >= QUEUE_DEPTH) begin
					// dropped anyway, so any width of delay is safe here
					delay = $urandom();
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 5)
						delay = '0;
					else if (sel < 60)
						delay = $urandom_range(1, 4);
					else if (sel < 88)
						delay = $urandom_range(5, 24);
					else
						delay = $urandom_range(25, 300);
				end
				offer_item(KIND_ALARM, 8'($urandom_range(0, 255)), delay);
			end
		end
		wait_for_drain();
	endtask

	// output side: random stalls and the check of every transfer
	initial begin
		timer_event_t want;
		int           gap;
		m_axis_tready = 1'b0;
		rx_holding = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, rx_max_gap);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			forever begin
				@(posedge clk);
				if (m_axis_tvalid && m_axis_tready)
					break;
				@(negedge clk);
				if (rx_hold_req > 0) begin
					rx_holding = 1'b1;
					m_axis_tready <= 1'b0;
					repeat (rx_hold_req) @(negedge clk);
					rx_hold_req = 0;
					rx_holding = 1'b0;
					m_axis_tready <= 1'b1;
				end
			end
			if (awaited_events.size() == 0) begin
				report_mismatch("unexpected result tdata", 0, m_axis_tdata);
			end else begin
				want = awaited_events[0];
				awaited_events.delete(0);
				if (m_axis_tuser !== want.is_release)
					report_mismatch("event_res", want.is_release, m_axis_tuser);
				if (m_axis_tdata[7:0] !== want.task_id)
					report_mismatch("released_task", want.task_id, m_axis_tdata[7:0]);
				if (m_axis_tdata[9:8] !== want.status)
					report_mismatch("status", want.status, m_axis_tdata[9:8]);
				if (m_axis_tdata[15:10] !== 6'd0)
					report_mismatch("tdata padding", 0, m_axis_tdata[15:10]);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", want.last, m_axis_tlast);
			end
			results_checked++;
			@(negedge clk);
		end
	end

	// ends the run once neither stream has moved for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
			$realtime, WATCHDOG_LIMIT, awaited_events.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int i;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		tx_max_gap    = 12;
		rx_max_gap    = 12;
		rx_hold_req   = 0;
		shadow_count  = 0;
		for (i = 0; i < QUEUE_DEPTH; i++) begin
			shadow_delta[i] = '0;
			shadow_task[i]  = '0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_request_edges();
		test_full_queue();
		test_random_traffic(125, 55, 12, 12);
		test_output_stall();
		test_random_traffic(125, 45, 0, 0);
		test_random_traffic(125, 62, 12, 0);
		test_random_traffic(40, 50, 0, 12);

		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (END_PAUSE) @(posedge clk);

		$display("covered %0d alarm requests (%0d full, %0d zero delay) and %0d ticks",
			requests_sent, full_due, ignored_due, ticks_sent);
		$display("checked %0d results, %0d of them task releases, %0d mismatches",
			results_checked, releases_due, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/dltq_pkg.sv
hw/rtl/dltq_cell.sv
hw/rtl/dltq_ctrl.sv
hw/rtl/delta_list_timer_queue_unit.sv
bench/delta_list_timer_queue_unit_test.sv
